// File: design/esk_pkg.sv
// Shared constants and types for the exchange sort block.
package esk_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int AW        = $clog2(MAX_ITEMS);
	localparam int CW        = $clog2(MAX_ITEMS + 1);
	localparam int KEY_W     = 16;
	localparam int PAY_W     = 20;
	localparam int ENT_W     = KEY_W + PAY_W;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [PAY_W-1:0] pay_t;
	typedef logic [AW-1:0]    addr_t;
	typedef logic [CW-1:0]    count_t;

	typedef struct packed {
		key_t key;
		pay_t pay;
	} entry_t;

	typedef struct packed {
		key_t sort_key;
		pay_t payload;
		logic last_item;
	} in_item_t;

	typedef struct packed {
		key_t out_key;
		pay_t out_payload;
		logic out_last;
		logic overflow_flag;
	} out_item_t;

endpackage

// File: design/esk_in_if.sv
// Input channel carrying key and payload transactions.
interface esk_in_if;
	logic               valid;
	logic               ready;
	esk_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

// File: design/esk_out_if.sv
// Output channel carrying sorted result transactions.
interface esk_out_if;
	logic               valid;
	logic               ready;
	esk_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

// File: design/exchange_sort_key_payload.sv
// Exchange sort of key and payload lists held in one RAM.
//
//  channel   dir  handshake     carries
//  items     in   valid/ready   sort_key, payload, last_item
//  results   out  valid/ready   out_key, out_payload, out_last, overflow_flag
//
// Load accepts one transaction per cycle. The sort of n entries runs through
// the single RAM read port, one compare a cycle. Emission reads each result
// from the RAM and then captures it into the output register, holding while
// the output is stalled. Reset clears control state only; the RAM holds no
// reset value. Input is held off from the last transaction of a list until
// its final result is in the output register.
module exchange_sort_key_payload (
	input  logic          clk,
	input  logic          arst_n,
	esk_in_if.sink        items,
	esk_out_if.source     results
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_RDI   = 3'd1;
	localparam logic [2:0] ST_LDI   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_WRI   = 3'd4;
	localparam logic [2:0] ST_EMRD  = 3'd5;
	localparam logic [2:0] ST_EMCAP = 3'd6;

	logic [2:0]          state_q;
	esk_pkg::count_t     cnt_q;
	logic                drop_q;
	esk_pkg::count_t     n_q;
	esk_pkg::addr_t      i_q;
	esk_pkg::count_t     j_q;
	esk_pkg::addr_t      pend_q;
	logic                pend_vld_q;
	esk_pkg::entry_t     cur_q;
	esk_pkg::addr_t      k_q;
	esk_pkg::out_item_t  out_q;
	logic                out_vld_q;

	logic                   we;
	esk_pkg::addr_t         waddr;
	esk_pkg::entry_t        wdata;
	logic                   re;
	esk_pkg::addr_t         raddr;
	logic [esk_pkg::ENT_W-1:0] rdata;
	esk_pkg::entry_t        rd_ent;

	logic             in_acc;
	logic             out_acc;
	logic             full;
	logic             swap;
	logic             out_free;
	logic             k_last;
	esk_pkg::count_t  n_acc;

	esk_ram #(
		.WIDTH (esk_pkg::ENT_W),
		.DEPTH (esk_pkg::MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_ent        = esk_pkg::entry_t'(rdata);
	assign items.ready   = (state_q == ST_LOAD);
	assign in_acc        = items.valid & items.ready;
	assign out_acc       = results.valid & results.ready;
	assign full          = (cnt_q == esk_pkg::CW'(esk_pkg::MAX_ITEMS));
	assign n_acc         = full ? cnt_q : cnt_q + esk_pkg::CW'(1);
	assign swap          = pend_vld_q && (cur_q.key > rd_ent.key);
	assign out_free      = !out_vld_q || results.ready;
	assign k_last        = ((esk_pkg::CW'(k_q) + esk_pkg::CW'(1)) == n_q);
	assign results.valid = out_vld_q;
	assign results.data  = out_q;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && !full) begin
					we    = 1'b1;
					waddr = cnt_q[esk_pkg::AW-1:0];
					wdata = '{key: items.data.sort_key, pay: items.data.payload};
				end
			end
			ST_RDI: begin
				re    = 1'b1;
				raddr = i_q;
			end
			ST_LDI: begin
				re    = 1'b1;
				raddr = i_q + esk_pkg::AW'(1);
			end
			ST_SCAN: begin
				if (swap) begin
					we    = 1'b1;
					waddr = pend_q;
					wdata = cur_q;
				end
				if (j_q < n_q) begin
					re    = 1'b1;
					raddr = j_q[esk_pkg::AW-1:0];
				end
			end
			ST_WRI: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = cur_q;
				re    = 1'b1;
				raddr = i_q + esk_pkg::AW'(1);
			end
			ST_EMRD: begin
				re    = 1'b1;
				raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_EMCAP && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_acc) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + esk_pkg::CW'(1);
						end
						if (items.data.last_item) begin
							n_q   <= n_acc;
							i_q   <= '0;
							k_q   <= '0;
							state_q <= (n_acc > esk_pkg::CW'(1)) ? ST_RDI : ST_EMRD;
						end
					end
				end
				ST_RDI: begin
					state_q <= ST_LDI;
				end
				ST_LDI: begin
					cur_q      <= rd_ent;
					pend_q     <= i_q + esk_pkg::AW'(1);
					pend_vld_q <= 1'b1;
					j_q        <= esk_pkg::CW'(i_q) + esk_pkg::CW'(2);
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (swap) begin
						cur_q <= rd_ent;
					end
					if (j_q < n_q) begin
						pend_q     <= j_q[esk_pkg::AW-1:0];
						pend_vld_q <= 1'b1;
						j_q        <= j_q + esk_pkg::CW'(1);
					end else begin
						pend_vld_q <= 1'b0;
					end
					if (!pend_vld_q) begin
						state_q <= ST_WRI;
					end
				end
				ST_WRI: begin
					if ((esk_pkg::CW'(i_q) + esk_pkg::CW'(2)) < n_q) begin
						i_q     <= i_q + esk_pkg::AW'(1);
						state_q <= ST_LDI;
					end else begin
						k_q     <= '0;
						state_q <= ST_EMRD;
					end
				end
				ST_EMRD: begin
					state_q <= ST_EMCAP;
				end
				ST_EMCAP: begin
					if (out_free) begin
						if (k_last) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + esk_pkg::AW'(1);
							state_q <= ST_EMRD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMCAP && out_free) begin
			out_q.out_key       <= rd_ent.key;
			out_q.out_payload   <= rd_ent.pay;
			out_q.out_last      <= k_last;
			out_q.overflow_flag <= drop_q;
		end
	end

endmodule

// File: design/esk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module esk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/esk_chk.sv
// Port-level checker for the exchange sort block and its bind.
module esk_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_last,
	input logic                out_valid,
	input logic                out_ready,
	input esk_pkg::out_item_t  out_data
);

	logic            in_list_q;
	esk_pkg::key_t   prev_key_q;
	logic            prev_ovf_q;
	logic            out_acc;

	assign out_acc = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_list_q  <= 1'b0;
			prev_key_q <= '0;
			prev_ovf_q <= 1'b0;
		end else if (out_acc) begin
			in_list_q  <= !out_data.out_last;
			prev_key_q <= out_data.out_key;
			prev_ovf_q <= out_data.overflow_flag;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result transaction changed while stalled");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken right after closing transaction");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_list_q |-> out_data.out_key >= prev_key_q)
		else $error("sorted keys descend within a list");

	a_ovf_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_list_q |-> out_data.overflow_flag == prev_ovf_q)
		else $error("overflow flag changed within a list");

endmodule

bind exchange_sort_key_payload esk_chk u_esk_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_last   (items.data.last_item),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);
